// ===== hdl/wcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wcsd_pkg: shared constants and types for the scene cut detector
// Window geometry, arithmetic widths and the request/response bundles
// passed between the sequencer, the similarity tester and the multiplier.
// ----------------------------------------------------------------------------
package wcsd_pkg;

  // window geometry
  localparam int unsigned WINDOW_DEPTH = 10;
  localparam int unsigned FEATURE_LEN  = 512;

  // input element and threshold
  localparam int unsigned X_W       = 16;
  localparam int unsigned THR_W     = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd45875;

  // derived widths
  localparam int unsigned PROD_W  = 2 * X_W;
  localparam int unsigned NORM_W  = 31 + $clog2(FEATURE_LEN);
  localparam int unsigned DOT_W   = NORM_W + 1;
  localparam int unsigned THR2_W  = 2 * THR_W;
  localparam int unsigned MUL_BW  = (NORM_W > THR2_W) ? NORM_W : THR2_W;
  localparam int unsigned MUL_AW  = 2 * NORM_W + THR2_W;
  localparam int unsigned LHS_SHIFT = 32;
  localparam int unsigned FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned POS_W   = $clog2(FEATURE_LEN + 1);
  localparam int unsigned RAM_DEPTH = WINDOW_DEPTH * FEATURE_LEN;
  localparam int unsigned RAM_AW  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int unsigned OUT_FILL_W = 4;

  // multiplier request and response
  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_AW-1:0] p;
  } mul_rsp_t;

  // similarity test response
  typedef struct packed {
    logic done;
    logic similar;
  } cmp_rsp_t;

endpackage

// ===== hdl/wcsd_ram.sv =====
// ----------------------------------------------------------------------------
// wcsd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wcsd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/wcsd_mul.sv =====
// ----------------------------------------------------------------------------
// wcsd_mul: shift-add multiplier
// One multiplier bit per cycle; finishes early once the remaining bits are 0.
// ----------------------------------------------------------------------------
module wcsd_mul import wcsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic              busy_q, done_q;
  logic [MUL_AW-1:0] acc_q, a_q;
  logic [MUL_BW-1:0] b_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath: add shifted multiplicand per set bit
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

// ===== hdl/wcsd_cmp.sv =====
// ----------------------------------------------------------------------------
// wcsd_cmp: exact cosine similarity test for one window slot
// Checks dot >= 0 and dot^2 * 2^32 >= thr^2 * na * nb with four passes
// through the shared shift-add multiplier. Operands must hold until done.
// ----------------------------------------------------------------------------
module wcsd_cmp import wcsd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DOT_W-1:0] dot_i,
  input  logic [NORM_W-1:0]       na_i,
  input  logic [NORM_W-1:0]       nb_i,
  input  logic [THR_W-1:0]        thr_i,
  output cmp_rsp_t                rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_THR,
    S_DD,
    S_NN,
    S_RHS
  } state_e;

  state_e            state_q;
  mul_req_t          mreq_q;
  mul_rsp_t          mrsp;
  logic [THR2_W-1:0] thr2_q;
  logic [MUL_AW-1:0] lhs_q;
  logic [MUL_AW-1:0] lhs_sh;
  logic              done_q, sim_q;

  assign lhs_sh = lhs_q << LHS_SHIFT;

  wcsd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq_q),
    .rsp_o  (mrsp)
  );

  // sequencer: thr^2, dot^2, na*nb, then (na*nb)*thr^2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mreq_q  <= '0;
      thr2_q  <= '0;
      lhs_q   <= '0;
      done_q  <= 1'b0;
      sim_q   <= 1'b0;
    end else begin
      mreq_q.start <= 1'b0;
      done_q       <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if ((na_i == '0) || (nb_i == '0)) begin
              // zero norm: similarity taken as 0
              sim_q  <= (thr_i == '0);
              done_q <= 1'b1;
            end else if (dot_i < 0) begin
              sim_q  <= 1'b0;
              done_q <= 1'b1;
            end else begin
              mreq_q.start <= 1'b1;
              mreq_q.a     <= MUL_AW'(thr_i);
              mreq_q.b     <= MUL_BW'(thr_i);
              state_q      <= S_THR;
            end
          end
        end
        S_THR: begin
          if (mrsp.done) begin
            thr2_q       <= mrsp.p[THR2_W-1:0];
            mreq_q.start <= 1'b1;
            mreq_q.a     <= MUL_AW'(dot_i[NORM_W-1:0]);
            mreq_q.b     <= MUL_BW'(dot_i[NORM_W-1:0]);
            state_q      <= S_DD;
          end
        end
        S_DD: begin
          if (mrsp.done) begin
            lhs_q        <= mrsp.p;
            mreq_q.start <= 1'b1;
            mreq_q.a     <= MUL_AW'(na_i);
            mreq_q.b     <= MUL_BW'(nb_i);
            state_q      <= S_NN;
          end
        end
        S_NN: begin
          if (mrsp.done) begin
            mreq_q.start <= 1'b1;
            mreq_q.a     <= mrsp.p;
            mreq_q.b     <= MUL_BW'(thr2_q);
            state_q      <= S_RHS;
          end
        end
        S_RHS: begin
          if (mrsp.done) begin
            sim_q   <= (lhs_sh >= mrsp.p);
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.similar = sim_q;

endmodule

// ===== hdl/window_cosine_scene_cut_detector_unit.sv =====
// ----------------------------------------------------------------------------
// window_cosine_scene_cut_detector_unit: windowed cosine scene cut detector
// Accumulates per-frame dot products against a window of earlier frame
// vectors and flags frames that resemble none of them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one beat per feature element,
//   last_element_i marks the frame's final beat. Elements past FEATURE_LEN
//   are dropped, but their last marker still ends the frame.
//   Output channel (out_valid_o / out_stall_i): one beat per finished frame.
//   Config channel (cfg_valid_i / cfg_ready_o): threshold write, always ready.
//   Datapath: one shared 16x16 multiplier and one read port of the window
//   memory serve the norm term and each stored vector in turn, holding
//   in_stall_o while an element is issued. With a full window each of
//   the ten slots runs up to four shift-add products in turn.
//   Reset empties the window, clears the accumulators and frame counter and
//   loads the default threshold; the memory itself is not cleared.
//   A finished result waits in the output register while the next frame is
//   taken; only a second frame end blocks while the receiver stalls.
// ----------------------------------------------------------------------------
module window_cosine_scene_cut_detector_unit import wcsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input elements
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [X_W-1:0] feature_value_i,
  input  logic                  last_element_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           frame_index_o,
  output logic                  scene_change_o,
  output logic                  compared_o,
  output logic [OUT_FILL_W-1:0] window_fill_o,
  // threshold register
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [THR_W-1:0]      similarity_threshold_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WRITE,
    S_FIN,
    S_CMP_GO,
    S_CMP_WAIT,
    S_EMIT
  } state_e;

  state_e state_q;

  // frame state
  logic signed [DOT_W-1:0] dot_q [WINDOW_DEPTH];
  logic [NORM_W-1:0]       norm_q [WINDOW_DEPTH];
  logic [POS_W-1:0]        len_q [WINDOW_DEPTH];
  logic [NORM_W-1:0]       cur_norm_q;
  logic [FILL_W-1:0]       fill_q, op_q;
  logic [SLOT_W-1:0]       oldest_q, cmp_slot_q;
  logic [POS_W-1:0]        pos_q;
  logic [RAM_AW-1:0]       rbase_q, wbase_q;
  logic [31:0]             frame_q;
  logic [THR_W-1:0]        thr_q;
  logic signed [X_W-1:0]   x_q;
  logic                    last_q, any_sim_q, chg_q, cmpd_q;

  // multiply pipeline
  logic                     s1_vld_q, s1_norm_q, s2_vld_q, s2_norm_q;
  logic [SLOT_W-1:0]        s1_slot_q, s2_slot_q;
  logic signed [PROD_W-1:0] prod_q, prod_d, xe, oe;
  logic signed [X_W-1:0]    opnd, rdata;

  // output register
  logic                  out_vld_q, chg_out_q, cmp_out_q;
  logic [31:0]           fidx_out_q;
  logic [OUT_FILL_W-1:0] fill_out_q;

  // handshakes and misc control
  logic              in_acc, iss_read, ram_we, fill_lt, commit_app, commit_cmp;
  logic              no_cut, norm_we, last_slot, pipe_busy;
  logic [SLOT_W-1:0] wr_slot, iss_slot;
  logic [RAM_AW-1:0] raddr, waddr;
  cmp_rsp_t          crsp;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign fill_lt    = (fill_q < FILL_W'(WINDOW_DEPTH));
  assign wr_slot    = fill_lt ? SLOT_W'(fill_q) : oldest_q;
  assign iss_slot   = SLOT_W'(op_q - FILL_W'(1));
  assign iss_read   = (state_q == S_ISSUE) && (op_q != '0);
  assign raddr      = rbase_q + RAM_AW'(pos_q);
  assign waddr      = wbase_q + RAM_AW'(pos_q);
  assign ram_we     = (state_q == S_WRITE);
  assign pipe_busy  = s1_vld_q || s2_vld_q;
  assign last_slot  = (cmp_slot_q == SLOT_W'(WINDOW_DEPTH - 1));
  assign commit_app = (state_q == S_FIN) && !pipe_busy && fill_lt;
  assign commit_cmp = (state_q == S_CMP_WAIT) && crsp.done && last_slot;
  assign no_cut     = any_sim_q || crsp.similar;
  assign norm_we    = commit_app || (commit_cmp && no_cut);

  wcsd_ram #(
    .WIDTH (X_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (x_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  wcsd_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_CMP_GO),
    .dot_i   (dot_q[cmp_slot_q]),
    .na_i    (norm_q[cmp_slot_q]),
    .nb_i    (cur_norm_q),
    .thr_i   (thr_q),
    .rsp_o   (crsp)
  );

  // multiply stage: positions past a slot's stored length read as zero
  always_comb begin
    if (s1_norm_q) begin
      opnd = x_q;
    end else if (pos_q < len_q[s1_slot_q]) begin
      opnd = rdata;
    end else begin
      opnd = '0;
    end
    xe     = PROD_W'(x_q);
    oe     = PROD_W'(opnd);
    prod_d = xe * oe;
  end

  // sequencer, accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        dot_q[i] <= '0;
      end
      cur_norm_q <= '0;
      fill_q     <= '0;
      op_q       <= '0;
      oldest_q   <= '0;
      cmp_slot_q <= '0;
      pos_q      <= '0;
      rbase_q    <= '0;
      wbase_q    <= '0;
      frame_q    <= '0;
      thr_q      <= THR_RESET;
      last_q     <= 1'b0;
      any_sim_q  <= 1'b0;
      chg_q      <= 1'b0;
      cmpd_q     <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      chg_out_q  <= 1'b0;
      cmp_out_q  <= 1'b0;
      fidx_out_q <= '0;
      fill_out_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= similarity_threshold_i;
      end
      if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end

      // pipeline valids and accumulation
      s1_vld_q <= (state_q == S_ISSUE);
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q) begin
        if (s2_norm_q) begin
          cur_norm_q <= cur_norm_q + NORM_W'(prod_q);
        end else begin
          dot_q[s2_slot_q] <= dot_q[s2_slot_q] + DOT_W'(prod_q);
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            last_q <= last_element_i;
            if (pos_q < POS_W'(FEATURE_LEN)) begin
              op_q    <= '0;
              rbase_q <= '0;
              state_q <= S_ISSUE;
            end else if (last_element_i) begin
              state_q <= S_FIN;
            end
          end
        end
        S_ISSUE: begin
          if (iss_read) begin
            rbase_q <= rbase_q + RAM_AW'(FEATURE_LEN);
          end
          if (op_q == fill_q) begin
            state_q <= S_WRITE;
          end else begin
            op_q <= op_q + FILL_W'(1);
          end
        end
        S_WRITE: begin
          pos_q   <= pos_q + POS_W'(1);
          state_q <= last_q ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (!pipe_busy) begin
            any_sim_q  <= 1'b0;
            cmp_slot_q <= '0;
            if (fill_lt) begin
              // append to a window that is not yet full
              fill_q  <= fill_q + FILL_W'(1);
              wbase_q <= (fill_q + FILL_W'(1) < FILL_W'(WINDOW_DEPTH)) ?
                         wbase_q + RAM_AW'(FEATURE_LEN) : '0;
              chg_q   <= 1'b0;
              cmpd_q  <= 1'b0;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_CMP_GO;
            end
          end
        end
        S_CMP_GO: begin
          state_q <= S_CMP_WAIT;
        end
        S_CMP_WAIT: begin
          if (crsp.done) begin
            any_sim_q <= no_cut;
            if (last_slot) begin
              chg_q  <= !no_cut;
              cmpd_q <= 1'b1;
              if (!no_cut) begin
                fill_q   <= '0;
                oldest_q <= '0;
                wbase_q  <= '0;
              end else if (oldest_q == SLOT_W'(WINDOW_DEPTH - 1)) begin
                oldest_q <= '0;
                wbase_q  <= '0;
              end else begin
                oldest_q <= oldest_q + SLOT_W'(1);
                wbase_q  <= wbase_q + RAM_AW'(FEATURE_LEN);
              end
              state_q <= S_EMIT;
            end else begin
              cmp_slot_q <= cmp_slot_q + SLOT_W'(1);
              state_q    <= S_CMP_GO;
            end
          end
        end
        S_EMIT: begin
          if (!out_vld_q || !out_stall_i) begin
            out_vld_q  <= 1'b1;
            fidx_out_q <= frame_q;
            chg_out_q  <= chg_q;
            cmp_out_q  <= cmpd_q;
            fill_out_q <= OUT_FILL_W'(fill_q);
            frame_q    <= frame_q + 32'd1;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
              dot_q[i] <= '0;
            end
            cur_norm_q <= '0;
            pos_q      <= '0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers without reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= feature_value_i;
    end
    s1_norm_q <= (op_q == '0);
    s1_slot_q <= iss_slot;
    s2_norm_q <= s1_norm_q;
    s2_slot_q <= s1_slot_q;
    prod_q    <= prod_d;
    if (norm_we) begin
      norm_q[wr_slot] <= cur_norm_q;
      len_q[wr_slot]  <= pos_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign frame_index_o  = fidx_out_q;
  assign scene_change_o = chg_out_q;
  assign compared_o     = cmp_out_q;
  assign window_fill_o  = fill_out_q;

  // checks
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill above depth");

  a_oldest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q < SLOT_W'(WINDOW_DEPTH))
    else $error("oldest slot out of range");

  a_idle_no_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !s1_vld_q)
    else $error("multiply stage busy while taking a new element");

  a_cmp_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP_GO) |-> (fill_q == FILL_W'(WINDOW_DEPTH)))
    else $error("comparison started with a partial window");

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !pipe_busy)
    else $error("frame closed with products in flight");

endmodule

// ===== tb/window_cosine_scene_cut_detector_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scene cut detector testbench
// Streams frames of feature elements through the detector under random
// valid and stall gaps. Each finished frame is predicted from a local
// copy of the window, and each result is checked field by field. The
// threshold is rewritten between phases, the extremes among the settings.
// ----------------------------------------------------------------------------
module window_cosine_scene_cut_detector_unit_tb;
  import wcsd_pkg::*;

  localparam int NUM_SCENES = 4;
  localparam int BASE_LEN   = 48;

  typedef struct {
    logic signed [X_W-1:0] value;
    logic                  last;
  } elem_t;

  typedef struct {
    logic [31:0]           index;
    logic                  cut;
    logic                  cmp;
    logic [OUT_FILL_W-1:0] fill;
  } frame_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [X_W-1:0] feature_value = '0;
  logic                  last_element = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [31:0]           frame_index;
  logic                  scene_change;
  logic                  compared;
  logic [OUT_FILL_W-1:0] window_fill;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [THR_W-1:0]      thr_data = '0;

  // beats waiting for the driver, frame results waiting for the monitor
  elem_t      elem_q[$];
  frame_res_t frame_res_q[$];

  // local copy of the detector state
  logic signed [X_W-1:0] win_mem [WINDOW_DEPTH*FEATURE_LEN];
  logic [47:0]           slot_norm_m [WINDOW_DEPTH];
  logic signed [47:0]    dot_acc [WINDOW_DEPTH];
  logic [47:0]           cur_norm;
  int                    fill_cnt, oldest, elem_pos;
  logic [31:0]           frame_no;
  logic [THR_W-1:0]      thr_now;

  logic signed [X_W-1:0] scene_base [NUM_SCENES][BASE_LEN];
  bit quiet = 1'b0;
  int errors = 0, frames_seen = 0, cuts_seen = 0, cmps_seen = 0;

  always #6 clk_i = ~clk_i;

  window_cosine_scene_cut_detector_unit dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .feature_value_i        (feature_value),
    .last_element_i         (last_element),
    .out_valid_o            (out_valid),
    .out_stall_i            (out_stall),
    .frame_index_o          (frame_index),
    .scene_change_o         (scene_change),
    .compared_o             (compared),
    .window_fill_o          (window_fill),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .similarity_threshold_i (thr_data)
  );

  // exact cosine test: dot >= 0 and dot^2 * 2^32 >= thr^2 * na * nb
  function automatic bit pair_similar(logic signed [47:0] dot, logic [47:0] na,
                                      logic [47:0] nb, logic [THR_W-1:0] thr);
    logic [159:0] lhs, rhs;
    if (na == 0 || nb == 0) return thr == 0;
    if (dot < 0) return 1'b0;
    lhs = 160'(dot) * 160'(dot);
    lhs = lhs << 32;
    rhs = 160'(na) * 160'(nb) * 160'(thr) * 160'(thr);
    return lhs >= rhs;
  endfunction

  // advance the local window by one accepted element
  task automatic track_element(logic signed [X_W-1:0] x, logic last);
    int slot;
    frame_res_t r;
    bit cut;
    slot = (fill_cnt < WINDOW_DEPTH) ? fill_cnt : oldest;
    if (elem_pos < FEATURE_LEN) begin
      for (int s = 0; s < fill_cnt; s++)
        dot_acc[s] += 48'(win_mem[s*FEATURE_LEN+elem_pos]) * 48'(x);
      cur_norm += 48'(48'(x) * 48'(x));
      win_mem[slot*FEATURE_LEN+elem_pos] = x;
      elem_pos++;
    end
    if (!last) return;
    for (int p = elem_pos; p < FEATURE_LEN; p++) win_mem[slot*FEATURE_LEN+p] = '0;
    r.cmp = 1'b0;
    cut = 1'b0;
    if (fill_cnt < WINDOW_DEPTH) begin
      slot_norm_m[slot] = cur_norm;
      fill_cnt++;
    end else begin
      r.cmp = 1'b1;
      cut = 1'b1;
      for (int s = 0; s < WINDOW_DEPTH; s++)
        if (pair_similar(dot_acc[s], slot_norm_m[s], cur_norm, thr_now)) cut = 1'b0;
      if (cut) begin
        fill_cnt = 0;
        oldest = 0;
      end else begin
        slot_norm_m[oldest] = cur_norm;
        oldest = (oldest + 1) % WINDOW_DEPTH;
      end
    end
    r.index = frame_no;
    r.cut = cut;
    r.fill = OUT_FILL_W'(fill_cnt);
    frame_res_q = {frame_res_q, r};
    frame_no++;
    for (int s = 0; s < WINDOW_DEPTH; s++) dot_acc[s] = '0;
    cur_norm = '0;
    elem_pos = 0;
  endtask

  // driver: one element beat per handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_element(feature_value, last_element);
        elem_q.delete(0);
      end
      if (!(in_valid && in_stall)) begin
        if (elem_q.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
          in_valid      <= 1'b1;
          feature_value <= elem_q[0].value;
          last_element  <= elem_q[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_res_q.size() == 0) begin
          $display("%0t: unexpected result beat, frame_index %0d", $time, frame_index);
          errors++;
        end else begin
          frame_res_t e;
          e = frame_res_q[0];
          frame_res_q.delete(0);
          if (frame_index !== e.index) begin
            $display("%0t: frame_index expected %0d actual %0d", $time, e.index, frame_index);
            errors++;
          end
          if (scene_change !== e.cut) begin
            $display("%0t: scene_change frame %0d expected %0b actual %0b",
                     $time, e.index, e.cut, scene_change);
            errors++;
          end
          if (compared !== e.cmp) begin
            $display("%0t: compared frame %0d expected %0b actual %0b",
                     $time, e.index, e.cmp, compared);
            errors++;
          end
          if (window_fill !== e.fill) begin
            $display("%0t: window_fill frame %0d expected %0d actual %0d",
                     $time, e.index, e.fill, window_fill);
            errors++;
          end
          frames_seen++;
          cuts_seen += e.cut;
          cmps_seen += e.cmp;
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  task automatic push_elem(int v, bit last);
    elem_t e;
    e.value = X_W'(v);
    e.last = last;
    elem_q = {elem_q, e};
  endtask

  // one frame drawn around a scene pattern, with occasional broken content
  task automatic push_frame(int scene, int len, bit zero_frame);
    int v;
    for (int i = 0; i < len; i++) begin
      if (zero_frame) v = 0;
      else if ($urandom_range(99) < 10) v = $signed(X_W'($urandom));
      else begin
        v = int'(scene_base[scene][i % BASE_LEN]) + int'($urandom_range(512)) - 256;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      push_elem(v, i == len - 1);
    end
  endtask

  // let every pending beat and result drain, then some settling time
  task automatic drain();
    @(posedge clk_i);
    while (elem_q.size() > 0 || in_valid || frame_res_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_valid <= 1'b1;
    thr_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    thr_now = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [THR_W-1:0] thr_plan [8];
    int scene, slen, n;
    thr_plan = '{17'd0, 17'd65536, 17'd65535, 17'd1, 17'd32768,
                 THR_RESET, 17'd60000, 17'd0};
    thr_plan[6] = THR_W'($urandom_range(65536));
    for (int s = 0; s < WINDOW_DEPTH; s++) begin
      dot_acc[s] = '0;
      slot_norm_m[s] = '0;
    end
    cur_norm = '0;
    fill_cnt = 0;
    oldest = 0;
    elem_pos = 0;
    frame_no = '0;
    thr_now = THR_RESET;
    for (int s = 0; s < NUM_SCENES; s++)
      for (int i = 0; i < BASE_LEN; i++) scene_base[s][i] = X_W'($urandom);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, zero norm, window fill then comparisons
    push_elem(32767, 0); push_elem(-32768, 1);
    push_elem(-32768, 1);
    push_elem(0, 1);
    push_elem(32767, 1);
    push_elem(1, 0); push_elem(-1, 1);
    push_elem(256, 1);
    push_elem(-256, 0); push_elem(0, 0); push_elem(255, 1);
    push_elem(21845, 1);
    push_elem(-21846, 1);
    push_elem(100, 1);
    push_elem(32767, 0); push_elem(-32768, 1);
    push_elem(0, 1);
    push_elem(-5, 0); push_elem(7, 1);
    push_elem(1, 1);
    drain();

    // random phases, threshold rewritten between them
    for (int ph = 0; ph < 8; ph++) begin
      write_threshold(thr_plan[ph]);
      quiet = (ph == 3);
      scene = 0;
      slen = $urandom_range(1, 12);
      n = 0;
      if (ph == 2) begin
        // overlong frame: the tail past the feature length is dropped
        push_frame(scene, FEATURE_LEN + 3, 1'b0);
        n += FEATURE_LEN + 3;
      end
      while (n < 85) begin
        int len;
        if ($urandom_range(99) < 15) begin
          scene = $urandom_range(NUM_SCENES - 1);
          slen = $urandom_range(1, 12);
        end
        if ($urandom_range(99) < 70) len = slen;
        else if ($urandom_range(99) < 85) len = $urandom_range(1, 12);
        else len = $urandom_range(13, 40);
        push_frame(scene, len, $urandom_range(99) < 3);
        n += len;
      end
      drain();
    end
    quiet = 1'b0;

    repeat (100) @(posedge clk_i);
    $display("Checked %0d frames: %0d compared against a full window, %0d scene cuts,",
             frames_seen, cmps_seen, cuts_seen);
    $display("over eight threshold settings including 0 and 1.0.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
